// ===== sv/fgac_pkg.sv =====
// constants, register indexes and helpers for the follower gap acceleration controller
package fgac_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_BOUNDS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ACCEL     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPEED     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_GAP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_WINDOW     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITS         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BOOST    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_BOOST    = 4'd7;

    localparam logic [1:0] SPEED_STAGE_LOW  = 2'd0;
    localparam logic [1:0] SPEED_STAGE_MID  = 2'd1;
    localparam logic [1:0] SPEED_STAGE_HIGH = 2'd2;

    localparam int PIPE_DEPTH = 7;

    // rounding: floor((acc*10000 + term*8192 + 40960000) / 81920000)
    localparam int ACC_W = 38;
    localparam int FRAC_SHIFT = 13;
    localparam logic signed [31:0] HALF_STEP = 32'sd5000;
    localparam logic [26:0] STEP_SCALE = 27'd10000;

    // floor(w / 625) by reciprocal, w biased positive and below 2^28
    localparam int DIV_IN_W = 28;
    localparam int DIV_SHIFT = 38;
    localparam logic [28:0] DIV_MAGIC = 29'd439804652;
    localparam logic [27:0] DIV_BIAS = 28'd81920000;
    localparam int QUO_W = 18;
    localparam logic signed [25:0] QUO_BIAS = 26'sd131072;

    typedef logic signed [15:0] q88_t;
    typedef logic signed [15:0] q412_t;

    function automatic logic [15:0] slot16(input logic [47:0] r, input logic [1:0] sel);
        logic [15:0] res;
        begin
            case (sel)
                SPEED_STAGE_LOW:  res = r[15:0];
                SPEED_STAGE_MID:  res = r[31:16];
                SPEED_STAGE_HIGH: res = r[47:32];
                default:          res = r[47:32];
            endcase
            return res;
        end
    endfunction

endpackage

// ===== sv/follower_gap_accel_control.sv =====
// follower gap-keeping acceleration law, seven-stage pipeline
//
//  channel   handshake              payload
//  in        in_valid / in_ready    lead_speed own_speed leader_accel gap_distance
//                                   brake_pedal accel_pedal
//  out       out_valid / out_ready  accel_command clamped
//  cfg       cfg_valid / cfg_ready  cfg_index cfg_data
//
// one item per cycle while the output is not stalled; the pipeline depth is set by the
// gain products, the pedal product and the divide by 625
// reset clears the valid bits and all configuration registers to zero
// a stall at the output freezes the whole pipeline; in_ready is high when out_ready is high or the last stage is empty
// cfg_ready is always high and a write to an index above seven is dropped
module follower_gap_accel_control
    import fgac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    lead_speed,
    input  logic signed [15:0]    own_speed,
    input  logic signed [15:0]    leader_accel,
    input  logic [15:0]           gap_distance,
    input  logic [6:0]            brake_pedal,
    input  logic [6:0]            accel_pedal,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    accel_command,
    output logic                  clamped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [31:0] speed_bounds_reg;
    logic [47:0] gain_accel_reg;
    logic [47:0] gain_speed_reg;
    logic [47:0] gain_gap_reg;
    logic [47:0] gap_window_reg;
    logic [47:0] limits_reg;
    logic [47:0] accel_boost_reg;
    logic [47:0] brake_boost_reg;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  advance;

    assign cfg_ready = 1'b1;
    assign advance   = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_bounds_reg <= '0;
            gain_accel_reg   <= '0;
            gain_speed_reg   <= '0;
            gain_gap_reg     <= '0;
            gap_window_reg   <= '0;
            limits_reg       <= '0;
            accel_boost_reg  <= '0;
            brake_boost_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SPEED_BOUNDS: speed_bounds_reg <= cfg_data[31:0];
                REG_GAIN_ACCEL:   gain_accel_reg   <= cfg_data;
                REG_GAIN_SPEED:   gain_speed_reg   <= cfg_data;
                REG_GAIN_GAP:     gain_gap_reg     <= cfg_data;
                REG_GAP_WINDOW:   gap_window_reg   <= cfg_data;
                REG_LIMITS:       limits_reg       <= cfg_data;
                REG_ACCEL_BOOST:  accel_boost_reg  <= cfg_data;
                REG_BRAKE_BOOST:  brake_boost_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // stage 0: speed stage, gain pick, differences, window and pedal choice
    logic [1:0]         stage_sel;
    logic signed [16:0] own_x;
    q412_t              ka_next, kv_next, kd_next;
    logic signed [16:0] dv_next;
    logic signed [17:0] err_next;
    logic               in_win_next;
    logic               brake_next;
    logic [6:0]         ped_next;
    logic               ped_on_next;
    logic [22:0]        thr100;
    logic [47:0]        boost;

    assign own_x = 17'(own_speed);

    always_comb
    begin
        if (own_x <= $signed({1'b0, speed_bounds_reg[15:0]}))
            stage_sel = SPEED_STAGE_LOW;
        else if (own_x <= $signed({1'b0, speed_bounds_reg[31:16]}))
            stage_sel = SPEED_STAGE_MID;
        else
            stage_sel = SPEED_STAGE_HIGH;
    end

    assign ka_next  = $signed(slot16(gain_accel_reg, stage_sel));
    assign kv_next  = $signed(slot16(gain_speed_reg, stage_sel));
    assign kd_next  = $signed(slot16(gain_gap_reg, stage_sel));
    assign dv_next  = 17'(lead_speed) - 17'(own_speed);
    assign err_next = $signed({2'b00, gap_distance}) - 18'($signed(gap_window_reg[15:0]));
    assign in_win_next = (err_next < 18'($signed(gap_window_reg[47:32])))
                      && (err_next > 18'($signed(gap_window_reg[31:16])));

    // brake wins whenever it is pressed at all, even below threshold
    assign brake_next  = (brake_pedal != 7'd0);
    assign ped_next    = brake_next ? brake_pedal : accel_pedal;
    assign thr100      = 23'(limits_reg[47:32]) * 23'd100;
    assign ped_on_next = ({ped_next, 16'h0000} > thr100);
    assign boost       = brake_next ? brake_boost_reg : accel_boost_reg;

    q412_t              s0_ka_reg, s0_kv_reg, s0_kd_reg;
    q88_t               s0_al_reg;
    logic signed [16:0] s0_dv_reg;
    logic signed [17:0] s0_err_reg;
    logic               s0_in_win_reg;
    logic               s0_brake_reg;
    logic [6:0]         s0_ped_reg;
    logic               s0_ped_on_reg;
    q88_t               s0_slope_reg, s0_offs_reg, s0_kmax_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_ka_reg     <= ka_next;
            s0_kv_reg     <= kv_next;
            s0_kd_reg     <= kd_next;
            s0_al_reg     <= leader_accel;
            s0_dv_reg     <= dv_next;
            s0_err_reg    <= err_next;
            s0_in_win_reg <= in_win_next;
            s0_brake_reg  <= brake_next;
            s0_ped_reg    <= ped_next;
            s0_ped_on_reg <= ped_on_next;
            s0_slope_reg  <= $signed(boost[15:0]);
            s0_offs_reg   <= $signed(boost[31:16]);
            s0_kmax_reg   <= $signed(boost[47:32]);
        end
    end

    // stage 1: gain products and the linear pedal gain
    logic signed [31:0] pa_next;
    logic signed [32:0] pv_next;
    logic signed [33:0] pd_next;
    logic signed [24:0] klin_next;
    logic signed [24:0] kcap_next;
    logic signed [7:0]  s0_ped_s;

    assign s0_ped_s  = $signed({1'b0, s0_ped_reg});
    assign pa_next   = 32'(s0_ka_reg) * 32'(s0_al_reg);
    assign pv_next   = 33'(s0_kv_reg) * 33'(s0_dv_reg);
    assign pd_next   = 34'(s0_kd_reg) * 34'(s0_err_reg);
    assign klin_next = 25'(s0_slope_reg) * 25'(s0_ped_s) + 25'(s0_offs_reg) * 25'sd100;
    assign kcap_next = 25'(s0_kmax_reg) * 25'sd100;

    logic signed [31:0] s1_pa_reg;
    logic signed [32:0] s1_pv_reg;
    logic signed [33:0] s1_pd_reg;
    logic               s1_in_win_reg;
    logic signed [24:0] s1_klin_reg, s1_kcap_reg;
    logic [6:0]         s1_ped_reg;
    logic               s1_ped_on_reg;
    logic               s1_brake_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pa_reg     <= pa_next;
            s1_pv_reg     <= pv_next;
            s1_pd_reg     <= pd_next;
            s1_in_win_reg <= s0_in_win_reg;
            s1_klin_reg   <= klin_next;
            s1_kcap_reg   <= kcap_next;
            s1_ped_reg    <= s0_ped_reg;
            s1_ped_on_reg <= s0_ped_on_reg;
            s1_brake_reg  <= s0_brake_reg;
        end
    end

    // stage 2: raw command at 2^-21 scale, capped pedal gain with its sign
    logic signed [ACC_W-1:0] sum3;
    logic signed [ACC_W-1:0] raw;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [24:0]      k100;
    logic signed [24:0]      keff_next;

    assign sum3 = ACC_W'(s1_pa_reg) + ACC_W'(s1_pv_reg)
                + (s1_in_win_reg ? ACC_W'(s1_pd_reg) : (ACC_W'(s1_pd_reg) <<< 2));
    assign raw      = s1_in_win_reg ? (sum3 <<< 1) : sum3;
    // negative commands are scaled by four
    assign acc_next = raw[ACC_W-1] ? (raw <<< 2) : raw;
    assign k100     = (s1_klin_reg > s1_kcap_reg) ? s1_kcap_reg : s1_klin_reg;
    assign keff_next = !s1_ped_on_reg ? 25'sd0 : (s1_brake_reg ? -k100 : k100);

    logic signed [ACC_W-1:0] s2_acc_reg;
    logic signed [24:0]      s2_keff_reg;
    logic [6:0]              s2_ped_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_acc_reg  <= acc_next;
            s2_keff_reg <= keff_next;
            s2_ped_reg  <= s1_ped_reg;
        end
    end

    // stage 3: pedal term, integer part and scaled fraction of the command
    logic signed [31:0] term_next;
    logic signed [24:0] q_next;
    logic [13:0]        frac_next;
    logic [26:0]        frac_prod;

    assign term_next = 32'(s2_keff_reg) * 32'($signed({1'b0, s2_ped_reg}));
    assign q_next    = 25'(s2_acc_reg >>> FRAC_SHIFT);
    assign frac_prod = 27'(s2_acc_reg[FRAC_SHIFT-1:0]) * STEP_SCALE;
    assign frac_next = 14'(frac_prod >> FRAC_SHIFT);

    logic signed [31:0] s3_term_reg;
    logic signed [24:0] s3_q_reg;
    logic [13:0]        s3_frac_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_term_reg <= term_next;
            s3_q_reg    <= q_next;
            s3_frac_reg <= frac_next;
        end
    end

    // stage 4: remainder sum over 10000, divided by 16 and biased positive
    logic signed [31:0]  zsum;
    logic [DIV_IN_W-1:0] wb_next;

    assign zsum    = s3_term_reg + HALF_STEP + 32'($signed({1'b0, s3_frac_reg}));
    assign wb_next = DIV_IN_W'(zsum >>> 4) + DIV_BIAS;

    logic [DIV_IN_W-1:0] s4_wb_reg;
    logic signed [24:0]  s4_q_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_wb_reg <= wb_next;
            s4_q_reg  <= s3_q_reg;
        end
    end

    // stage 5: divide by 625 through the reciprocal
    logic [56:0]      div_prod;
    logic [QUO_W-1:0] quo_next;

    assign div_prod = 57'(s4_wb_reg) * 57'(DIV_MAGIC);
    assign quo_next = div_prod[DIV_SHIFT+QUO_W-1:DIV_SHIFT];

    logic [QUO_W-1:0]   s5_quo_reg;
    logic signed [24:0] s5_q_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_quo_reg <= quo_next;
            s5_q_reg   <= s4_q_reg;
        end
    end

    // stage 6: rounded command and clamp, held for the consumer
    logic signed [25:0] val;
    logic signed [25:0] lim_x, dec_x;
    q88_t               cmd_next;
    logic               clamped_next;

    assign val   = 26'(s5_q_reg) + 26'($signed({1'b0, s5_quo_reg})) - QUO_BIAS;
    assign dec_x = 26'($signed(limits_reg[15:0]));
    assign lim_x = 26'($signed(limits_reg[31:16]));

    always_comb
    begin
        if (val > lim_x)
        begin
            cmd_next     = $signed(limits_reg[31:16]);
            clamped_next = 1'b1;
        end
        else if (val < dec_x)
        begin
            cmd_next     = $signed(limits_reg[15:0]);
            clamped_next = 1'b1;
        end
        else
        begin
            cmd_next     = 16'(val);
            clamped_next = 1'b0;
        end
    end

    q88_t cmd_reg;
    logic clamped_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg     <= cmd_next;
            clamped_reg <= clamped_next;
        end
    end

    assign accel_command = cmd_reg;
    assign clamped       = clamped_reg;

endmodule

// ===== dv/follower_gap_accel_control_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the follower gap acceleration controller
module follower_gap_accel_control_tb;
    import fgac_pkg::*;

    localparam int FIRST_UNUSED_IDX = 8;
    localparam int LAST_IDX = (1 << CFG_IDX_W) - 1;
    localparam longint CMD_ROUND_DEN = 64'sd81920000;

    typedef struct packed {
        logic signed [15:0] lead_speed;
        logic signed [15:0] own_speed;
        logic signed [15:0] leader_accel;
        logic [15:0]        gap_distance;
        logic [6:0]         brake_pedal;
        logic [6:0]         accel_pedal;
    } sensor_sample_t;

    typedef struct packed {
        logic signed [15:0] accel_command;
        logic               clamped;
    } accel_cmd_t;

    typedef enum int {
        SET_NOMINAL, SET_ALL_ONES, SET_MAX_GAIN, SET_MIN_GAIN, SET_RANDOM, SET_MODERATE
    } setting_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    lead_speed = '0;
    logic signed [15:0]    own_speed = '0;
    logic signed [15:0]    leader_accel = '0;
    logic [15:0]           gap_distance = '0;
    logic [6:0]            brake_pedal = '0;
    logic [6:0]            accel_pedal = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    accel_command;
    logic                  clamped;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [47:0]    cfg_shadow [8];
    sensor_sample_t sample_q[$];
    accel_cmd_t     cmd_expect_q[$];

    logic in_accepted = 1'b0;
    logic out_accepted = 1'b0;
    logic in_no_idle = 1'b0;
    logic out_no_idle = 1'b0;
    int   in_hold_left = 0;
    int   out_hold_left = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   clamped_seen = 0;
    int   negative_seen = 0;
    int   settings_used = 0;

    follower_gap_accel_control dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .lead_speed    (lead_speed),
        .own_speed     (own_speed),
        .leader_accel  (leader_accel),
        .gap_distance  (gap_distance),
        .brake_pedal   (brake_pedal),
        .accel_pedal   (accel_pedal),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accel_command (accel_command),
        .clamped       (clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic longint slot_s(input logic [47:0] r, input int k);
        logic signed [15:0] f;
        begin
            f = r[16*k +: 16];
            return longint'(f);
        end
    endfunction

    function automatic longint slot_u(input logic [47:0] r, input int k);
        logic [15:0] f;
        begin
            f = r[16*k +: 16];
            return longint'(f);
        end
    endfunction

    // 10000 * k * p at Q8.8, k = min(slope*p + offset, max), p = pedal / 100
    function automatic longint pedal_boost(input logic [47:0] boost, input longint pedal);
        longint k100;
        begin
            k100 = slot_s(boost, 0) * pedal + slot_s(boost, 1) * 100;
            if (k100 > slot_s(boost, 2) * 100)
                k100 = slot_s(boost, 2) * 100;
            return k100 * pedal;
        end
    endfunction

    function automatic accel_cmd_t predict_accel_command(input sensor_sample_t s);
        accel_cmd_t r;
        int     stage;
        longint vl, vo, al, gap, bp, ap, ka, kv, kd, gap_err, dv, lo, hi;
        longint raw, num, q, thr, dec_lim, acc_lim;
        begin
            vl = longint'(s.lead_speed);
            vo = longint'(s.own_speed);
            al = longint'(s.leader_accel);
            gap = longint'(s.gap_distance);
            bp = longint'(s.brake_pedal);
            ap = longint'(s.accel_pedal);

            if (vo <= slot_u(cfg_shadow[REG_SPEED_BOUNDS], 0))
                stage = 0;
            else if (vo <= slot_u(cfg_shadow[REG_SPEED_BOUNDS], 1))
                stage = 1;
            else
                stage = 2;
            ka = slot_s(cfg_shadow[REG_GAIN_ACCEL], stage);
            kv = slot_s(cfg_shadow[REG_GAIN_SPEED], stage);
            kd = slot_s(cfg_shadow[REG_GAIN_GAP], stage);

            gap_err = gap - slot_s(cfg_shadow[REG_GAP_WINDOW], 0);
            lo = slot_s(cfg_shadow[REG_GAP_WINDOW], 1);
            hi = slot_s(cfg_shadow[REG_GAP_WINDOW], 2);
            dv = vl - vo;

            // kept at 2^-21 so that halving the outer-window terms stays exact
            if (gap_err < hi && gap_err > lo)
                raw = 2 * (ka * al + kv * dv + kd * gap_err);
            else
                raw = ka * al + kv * dv + 4 * kd * gap_err;
            if (raw < 0)
                raw = raw * 4;

            num = raw * 10000;
            thr = slot_u(cfg_shadow[REG_LIMITS], 2);
            // brake takes the pedal path whenever pressed, even below threshold
            if (bp > 0)
            begin
                if (bp * 65536 > thr * 100)
                    num = num - pedal_boost(cfg_shadow[REG_BRAKE_BOOST], bp) * 8192;
            end
            else if (ap > 0)
            begin
                if (ap * 65536 > thr * 100)
                    num = num + pedal_boost(cfg_shadow[REG_ACCEL_BOOST], ap) * 8192;
            end

            // nearest, ties upward
            num = num + CMD_ROUND_DEN / 2;
            q = num / CMD_ROUND_DEN;
            if (num % CMD_ROUND_DEN != 0 && num < 0)
                q = q - 1;

            dec_lim = slot_s(cfg_shadow[REG_LIMITS], 0);
            acc_lim = slot_s(cfg_shadow[REG_LIMITS], 1);
            r.clamped = 1'b0;
            if (q > acc_lim)
            begin
                q = acc_lim;
                r.clamped = 1'b1;
            end
            else if (q < dec_lim)
            begin
                q = dec_lim;
                r.clamped = 1'b1;
            end
            r.accel_command = q[15:0];
            return r;
        end
    endfunction

    function automatic logic [15:0] rand_signed(input logic [15:0] span);
        return 16'($urandom_range(0, 2 * 32'(span)) - 32'(span));
    endfunction

    function automatic logic [47:0] pack3(input logic [15:0] a, b, c);
        return {c, b, a};
    endfunction

    function automatic sensor_sample_t random_sample();
        sensor_sample_t s;
        logic [15:0]    desired;
        begin
            s.lead_speed = 16'($urandom);
            s.own_speed = 16'($urandom);
            s.leader_accel = 16'($urandom);
            s.gap_distance = 16'($urandom);
            // mostly ordinary traffic, the rest anywhere in range
            if ($urandom_range(0, 9) < 6)
            begin
                s.lead_speed = 16'($urandom_range(0, 16'h3000));
                s.own_speed = 16'($urandom_range(0, 16'h3000));
                s.leader_accel = rand_signed(16'h0400);
            end
            case ($urandom_range(0, 5))
                0: s.own_speed = 16'(cfg_shadow[REG_SPEED_BOUNDS][15:0]
                                     + $urandom_range(0, 2) - 1);
                1: s.own_speed = 16'(cfg_shadow[REG_SPEED_BOUNDS][31:16]
                                     + $urandom_range(0, 2) - 1);
                default: ;
            endcase
            desired = cfg_shadow[REG_GAP_WINDOW][15:0];
            case ($urandom_range(0, 4))
                0: s.gap_distance = 16'(desired + cfg_shadow[REG_GAP_WINDOW][31:16]
                                        + $urandom_range(0, 4) - 2);
                1: s.gap_distance = 16'(desired + cfg_shadow[REG_GAP_WINDOW][47:32]
                                        + $urandom_range(0, 4) - 2);
                2: s.gap_distance = desired + rand_signed(16'h0800);
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0:
                begin
                    s.brake_pedal = '0;
                    s.accel_pedal = '0;
                end
                1:
                begin
                    s.brake_pedal = 7'($urandom_range(1, 127));
                    s.accel_pedal = '0;
                end
                2:
                begin
                    s.brake_pedal = '0;
                    s.accel_pedal = 7'($urandom_range(1, 127));
                end
                default:
                begin
                    s.brake_pedal = 7'($urandom_range(0, 127));
                    s.accel_pedal = 7'($urandom_range(0, 127));
                end
            endcase
            return s;
        end
    endfunction

    function automatic void queue_sample(input sensor_sample_t s);
        sample_q.push_back(s);
        items_sent++;
    endfunction

    function automatic void directed(input logic [15:0] ls, os, la, gap,
                                     input logic [6:0] bp, ap);
        sensor_sample_t s;
        begin
            s.lead_speed = ls;
            s.own_speed = os;
            s.leader_accel = la;
            s.gap_distance = gap;
            s.brake_pedal = bp;
            s.accel_pedal = ap;
            queue_sample(s);
        end
    endfunction

    // cfg_valid stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_SPEED_BOUNDS)
            cfg_shadow[idx] = {16'h0000, data[31:0]};
        else if (idx < FIRST_UNUSED_IDX)
            cfg_shadow[idx] = data;
    endtask

    task automatic apply_setting(input setting_t kind);
        logic [47:0]          v [8];
        logic [CFG_IDX_W-1:0] spare;
        int                   i;
        begin
            case (kind)
                SET_NOMINAL:
                begin
                    v[REG_SPEED_BOUNDS] = {16'h0000, 16'h1900, 16'h0A00};
                    v[REG_GAIN_ACCEL] = pack3(16'h0800, 16'h0A00, 16'h0C00);
                    v[REG_GAIN_SPEED] = pack3(16'h1000, 16'h1400, 16'h1800);
                    v[REG_GAIN_GAP] = pack3(16'h0400, 16'h0500, 16'h0600);
                    v[REG_GAP_WINDOW] = pack3(16'h1400, 16'hFE00, 16'h0300);
                    // threshold of 0.3
                    v[REG_LIMITS] = pack3(16'hFB00, 16'h0200, 16'h4CCD);
                    v[REG_ACCEL_BOOST] = pack3(16'h0100, 16'h0080, 16'h0100);
                    v[REG_BRAKE_BOOST] = pack3(16'h0200, 16'h0100, 16'h0180);
                end
                SET_ALL_ONES:
                    for (i = 0; i < 8; i++)
                        v[i] = '1;
                SET_MAX_GAIN:
                begin
                    // junk above bit 31 must be dropped by the bounds register
                    v[REG_SPEED_BOUNDS] = {16'hA5A5, 16'hFFFF, 16'h0000};
                    v[REG_GAIN_ACCEL] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
                    v[REG_GAIN_SPEED] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
                    v[REG_GAIN_GAP] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
                    v[REG_GAP_WINDOW] = pack3(16'h0000, 16'h8000, 16'h7FFF);
                    v[REG_LIMITS] = pack3(16'h8000, 16'h7FFF, 16'h0000);
                    v[REG_ACCEL_BOOST] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
                    v[REG_BRAKE_BOOST] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
                end
                SET_MIN_GAIN:
                begin
                    v[REG_SPEED_BOUNDS] = {16'h0000, 16'h0200, 16'h0100};
                    v[REG_GAIN_ACCEL] = pack3(16'h8000, 16'h8000, 16'h8000);
                    v[REG_GAIN_SPEED] = pack3(16'h8000, 16'h8000, 16'h8000);
                    v[REG_GAIN_GAP] = pack3(16'h8000, 16'h8000, 16'h8000);
                    // empty window, limits swapped
                    v[REG_GAP_WINDOW] = pack3(16'h8000, 16'h7FFF, 16'h8000);
                    v[REG_LIMITS] = pack3(16'h0100, 16'hFF00, 16'hFFFF);
                    v[REG_ACCEL_BOOST] = pack3(16'h8000, 16'h8000, 16'h8000);
                    v[REG_BRAKE_BOOST] = pack3(16'h8000, 16'h8000, 16'h8000);
                end
                SET_RANDOM:
                begin
                    for (i = 0; i < 8; i++)
                        v[i] = 48'({$urandom, $urandom});
                    if ($urandom_range(0, 1))
                    begin
                        v[REG_LIMITS][15:0] = 16'(16'h8000 + $urandom_range(0, 16'h7000));
                        v[REG_LIMITS][31:16] = 16'($urandom_range(16'h0800, 16'h7FFF));
                    end
                end
                default:
                begin
                    v[REG_SPEED_BOUNDS][15:0] = 16'($urandom_range(0, 16'h1800));
                    v[REG_SPEED_BOUNDS][31:16] = 16'(v[REG_SPEED_BOUNDS][15:0]
                                                     + $urandom_range(0, 16'h1800));
                    v[REG_SPEED_BOUNDS][47:32] = 16'($urandom);
                    v[REG_GAIN_ACCEL] = pack3(rand_signed(16'h2000), rand_signed(16'h2000),
                                              rand_signed(16'h2000));
                    v[REG_GAIN_SPEED] = pack3(rand_signed(16'h2000), rand_signed(16'h2000),
                                              rand_signed(16'h2000));
                    v[REG_GAIN_GAP] = pack3(rand_signed(16'h2000), rand_signed(16'h2000),
                                            rand_signed(16'h2000));
                    v[REG_GAP_WINDOW] = pack3(16'($urandom_range(16'h0200, 16'h4000)),
                                              16'(16'h0000 - $urandom_range(0, 16'h0600)),
                                              16'($urandom_range(0, 16'h0600)));
                    v[REG_LIMITS] = pack3(16'(16'h0000 - $urandom_range(16'h0100, 16'h0A00)),
                                          16'($urandom_range(16'h0100, 16'h0600)),
                                          16'($urandom));
                    v[REG_ACCEL_BOOST] = pack3(rand_signed(16'h0200), rand_signed(16'h0200),
                                               rand_signed(16'h0200));
                    v[REG_BRAKE_BOOST] = pack3(rand_signed(16'h0200), rand_signed(16'h0200),
                                               rand_signed(16'h0200));
                end
            endcase
            for (i = 0; i < 8; i++)
                write_reg(CFG_IDX_W'(i), v[i]);
            // a write past the last register must leave every register alone
            spare = CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX));
            write_reg(spare, 48'({$urandom, $urandom}));
            @(negedge clk);
            cfg_valid <= 1'b0;
            settings_used++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen < items_sent);
    endtask

    task automatic run_random(input int n);
        int i;
        begin
            in_no_idle = ($urandom_range(0, 3) == 0);
            out_no_idle = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n; i++)
                queue_sample(random_sample());
            wait_drained();
        end
    endtask

    // sensor item driver
    always @(negedge clk)
    begin : feed_samples
        sensor_sample_t s;
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (in_accepted)
                in_hold_left = in_no_idle ? 0 : $urandom_range(0, 19);
            if (in_hold_left > 0)
            begin
                in_hold_left--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                s = sample_q.pop_front();
                lead_speed <= s.lead_speed;
                own_speed <= s.own_speed;
                leader_accel <= s.leader_accel;
                gap_distance <= s.gap_distance;
                brake_pedal <= s.brake_pedal;
                accel_pedal <= s.accel_pedal;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // command receiver back-pressure
    always @(negedge clk)
    begin : pace_commands
        if (rst_n)
        begin
            if (out_accepted)
                out_hold_left = out_no_idle ? 0 : $urandom_range(0, 19);
            if (out_hold_left > 0)
            begin
                out_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_commands
        accel_cmd_t     want;
        sensor_sample_t taken;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (cmd_expect_q.size() == 0)
                begin
                    $error("unexpected command: accel_command %0d clamped %0b",
                           accel_command, clamped);
                    mismatch_count++;
                end
                else
                begin
                    want = cmd_expect_q.pop_front();
                    if (accel_command !== want.accel_command)
                    begin
                        $error("accel_command: expected %0d, got %0d",
                               want.accel_command, accel_command);
                        mismatch_count++;
                    end
                    if (clamped !== want.clamped)
                    begin
                        $error("clamped: expected %0b, got %0b", want.clamped, clamped);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken.lead_speed = lead_speed;
                taken.own_speed = own_speed;
                taken.leader_accel = leader_accel;
                taken.gap_distance = gap_distance;
                taken.brake_pedal = brake_pedal;
                taken.accel_pedal = accel_pedal;
                want = predict_accel_command(taken);
                if (want.clamped)
                    clamped_seen++;
                if (want.accel_command < 0)
                    negative_seen++;
                cmd_expect_q.push_back(want);
            end
        end
        in_accepted <= in_valid && in_ready;
        out_accepted <= out_valid && out_ready;
    end

    initial
    begin : run_stimulus
        int phase;
        for (phase = 0; phase < 8; phase++)
            cfg_shadow[phase] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // straight out of reset every register is zero
        directed(16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 7'd0);
        directed(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 7'd127, 7'd0);
        directed(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 7'd0, 7'd127);
        wait_drained();

        apply_setting(SET_NOMINAL);
        directed(16'h0000, 16'h0000, 16'h0000, 16'h1400, 7'd0, 7'd0);
        directed(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 7'd0, 7'd0);
        directed(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 7'd0, 7'd0);
        // gap error either side of both window edges
        directed(16'h0C00, 16'h0800, 16'h0080, 16'h1201, 7'd0, 7'd0);
        directed(16'h0C00, 16'h0800, 16'h0080, 16'h1200, 7'd0, 7'd0);
        directed(16'h0C00, 16'h0800, 16'h0080, 16'h16FF, 7'd0, 7'd0);
        directed(16'h0C00, 16'h0800, 16'h0080, 16'h1700, 7'd0, 7'd0);
        // own speed on and just past each stage bound, and reversing
        directed(16'h0A80, 16'h0A00, 16'h0040, 16'h1480, 7'd0, 7'd0);
        directed(16'h0A80, 16'h0A01, 16'h0040, 16'h1480, 7'd0, 7'd0);
        directed(16'h1980, 16'h1900, 16'h0040, 16'h1480, 7'd0, 7'd0);
        directed(16'h1980, 16'h1901, 16'h0040, 16'h1480, 7'd0, 7'd0);
        directed(16'h0100, 16'hF000, 16'h0000, 16'h1480, 7'd0, 7'd0);
        // closing in: negative command gets scaled up
        directed(16'h0800, 16'h0C00, 16'hFF00, 16'h1300, 7'd0, 7'd0);
        // brake has priority, even when too light to count
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd100, 7'd100);
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd1, 7'd100);
        // pedal fraction level with and just over the threshold
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd0, 7'd30);
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd0, 7'd31);
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd30, 7'd0);
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd31, 7'd0);
        // pedals past full travel
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd127, 7'd0);
        directed(16'h0800, 16'h0800, 16'h0000, 16'h1400, 7'd0, 7'd127);
        wait_drained();

        apply_setting(SET_ALL_ONES);
        run_random(40);
        apply_setting(SET_MAX_GAIN);
        run_random(40);
        apply_setting(SET_MIN_GAIN);
        run_random(40);
        for (phase = 0; phase < 10; phase++)
        begin
            if (phase % 3 == 0)
                apply_setting(SET_RANDOM);
            else if (phase % 3 == 1)
                apply_setting(SET_MODERATE);
            else
                apply_setting(SET_NOMINAL);
            run_random(100);
        end

        repeat (PIPE_DEPTH + 4) @(negedge clk);
        if (cmd_expect_q.size() != 0)
        begin
            $error("%0d expected commands never arrived", cmd_expect_q.size());
            mismatch_count++;
        end
        $display("checked %0d commands for %0d sensor items under %0d register settings",
                 results_seen, items_sent, settings_used);
        $display("%0d of them held at a limit, %0d negative, %0d mismatches",
                 clamped_seen, negative_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
